// ----- rtl/core/pqt_pkg.sv -----
//------------------------------------------------------------------------------
// Point-in-quad test package
// Shared constants and types for the point-in-quad ray casting block.
//------------------------------------------------------------------------------
`default_nettype none

package pqt_pkg;

	localparam int NUM_EDGES    = 4;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_PLANE    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_A = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_B = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_C = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_D = 3'd4;

	localparam int PLANE_BITS = 2;

	localparam logic [PLANE_BITS-1:0] PLANE_XY = 2'd0;
	localparam logic [PLANE_BITS-1:0] PLANE_YZ = 2'd1;
	localparam logic [PLANE_BITS-1:0] PLANE_XZ = 2'd2;

	typedef struct packed {
		logic cross_en;
		logic on_end;
		logic den_pos;
	} pqt_edge_flags_t;

	typedef pqt_edge_flags_t [NUM_EDGES-1:0] pqt_quad_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/pqt_if.sv -----
//------------------------------------------------------------------------------
// Point-in-quad test channels
// Valid/ready channels for the point beat and the result beat.
//------------------------------------------------------------------------------
`default_nettype none

interface pqt_point_if #(
	parameter int COORD_BITS = 24
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

interface pqt_result_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, output inside_res, input ready);
	modport sink (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/point_in_quad_test_top.sv -----
//------------------------------------------------------------------------------
// Point-in-quad test top level
// Projects each point and tests it against the configured quad by ray casting.
//------------------------------------------------------------------------------
// Pipeline: edge preparation, cross product and decision registers in turn.
// Throughput: one point per cycle; of the three pipeline stages, only valid
// ones stall, back from the output register while a result waits to be taken.
// Reset: arst_n clears the stage valid bits and all configuration registers.
//------------------------------------------------------------------------------
`default_nettype none

module point_in_quad_test_top #(
	parameter int COORD_BITS = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pqt_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [2*COORD_BITS-1:0]          cfg_data,
	pqt_point_if.sink                             point,
	pqt_result_if.source                          result
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic [pqt_pkg::PLANE_BITS-1:0]                  plane;
	logic [pqt_pkg::NUM_EDGES-1:0][2*COORD_BITS-1:0] vtx;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic adv1;
	logic adv2;
	logic adv3;

	logic signed [DW-1:0] dv_s1 [pqt_pkg::NUM_EDGES];
	logic signed [DW-1:0] dx_s1 [pqt_pkg::NUM_EDGES];
	logic signed [DW-1:0] du_s1 [pqt_pkg::NUM_EDGES];
	logic signed [DW-1:0] dy_s1 [pqt_pkg::NUM_EDGES];
	logic signed [PW-1:0] lhs_s2 [pqt_pkg::NUM_EDGES];
	logic signed [PW-1:0] rhs_s2 [pqt_pkg::NUM_EDGES];
	pqt_pkg::pqt_quad_flags_t flags_s1;
	pqt_pkg::pqt_quad_flags_t flags_s2;
	logic inside_s3;

	assign adv3 = !vld_s3 || result.ready;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= point.valid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
			if (adv3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	pqt_cfg_regs #(
		.COORD_BITS(COORD_BITS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.plane  (plane),
		.vtx    (vtx)
	);

	pqt_edge_prep #(
		.COORD_BITS(COORD_BITS)
	) u_prep (
		.clk      (clk),
		.en       (adv1),
		.plane    (plane),
		.vtx      (vtx),
		.px       (point.point_x),
		.py       (point.point_y),
		.pz       (point.point_z),
		.dv_s1    (dv_s1),
		.dx_s1    (dx_s1),
		.du_s1    (du_s1),
		.dy_s1    (dy_s1),
		.flags_s1 (flags_s1)
	);

	pqt_edge_mul #(
		.COORD_BITS(COORD_BITS)
	) u_mul (
		.clk      (clk),
		.en       (adv2),
		.dv_s1    (dv_s1),
		.dx_s1    (dx_s1),
		.du_s1    (du_s1),
		.dy_s1    (dy_s1),
		.flags_s1 (flags_s1),
		.lhs_s2   (lhs_s2),
		.rhs_s2   (rhs_s2),
		.flags_s2 (flags_s2)
	);

	pqt_decide #(
		.COORD_BITS(COORD_BITS)
	) u_decide (
		.clk       (clk),
		.en        (adv3),
		.lhs_s2    (lhs_s2),
		.rhs_s2    (rhs_s2),
		.flags_s2  (flags_s2),
		.inside_s3 (inside_s3)
	);

	assign point.ready       = adv1;
	assign result.valid      = vld_s3;
	assign result.inside_res = inside_s3;

endmodule

`default_nettype wire

// ----- rtl/core/pqt_cfg_regs.sv -----
//------------------------------------------------------------------------------
// Point-in-quad configuration registers
// Holds the projection plane and the four quad vertices.
//------------------------------------------------------------------------------
`default_nettype none

module pqt_cfg_regs #(
	parameter int COORD_BITS = 24
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   we,
	input  wire logic [pqt_pkg::CFG_IDX_BITS-1:0]       index,
	input  wire logic [2*COORD_BITS-1:0]                data,
	output logic [pqt_pkg::PLANE_BITS-1:0]              plane,
	output logic [pqt_pkg::NUM_EDGES-1:0][2*COORD_BITS-1:0] vtx
);

	logic [pqt_pkg::PLANE_BITS-1:0]                  plane_q;
	logic [pqt_pkg::NUM_EDGES-1:0][2*COORD_BITS-1:0] vtx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
			vtx_q   <= '0;
		end else if (we) begin
			unique case (index)
				pqt_pkg::REG_PLANE:    plane_q  <= data[pqt_pkg::PLANE_BITS-1:0];
				pqt_pkg::REG_VERTEX_A: vtx_q[0] <= data;
				pqt_pkg::REG_VERTEX_B: vtx_q[1] <= data;
				pqt_pkg::REG_VERTEX_C: vtx_q[2] <= data;
				pqt_pkg::REG_VERTEX_D: vtx_q[3] <= data;
				default: ;
			endcase
		end
	end

	assign plane = plane_q;
	assign vtx   = vtx_q;

endmodule

`default_nettype wire

// ----- rtl/core/pqt_edge_prep.sv -----
//------------------------------------------------------------------------------
// Point-in-quad edge preparation stage
// Projects the point, forms the edge differences and the edge flags.
//------------------------------------------------------------------------------
`default_nettype none

module pqt_edge_prep #(
	parameter int COORD_BITS = 24,
	localparam int DW = COORD_BITS + 1
) (
	input  wire logic                                       clk,
	input  wire logic                                       en,
	input  wire logic [pqt_pkg::PLANE_BITS-1:0]             plane,
	input  wire logic [pqt_pkg::NUM_EDGES-1:0][2*COORD_BITS-1:0] vtx,
	input  wire logic signed [COORD_BITS-1:0]               px,
	input  wire logic signed [COORD_BITS-1:0]               py,
	input  wire logic signed [COORD_BITS-1:0]               pz,
	output logic signed [DW-1:0]                            dv_s1 [pqt_pkg::NUM_EDGES],
	output logic signed [DW-1:0]                            dx_s1 [pqt_pkg::NUM_EDGES],
	output logic signed [DW-1:0]                            du_s1 [pqt_pkg::NUM_EDGES],
	output logic signed [DW-1:0]                            dy_s1 [pqt_pkg::NUM_EDGES],
	output pqt_pkg::pqt_quad_flags_t                        flags_s1
);

	logic signed [COORD_BITS-1:0] u;
	logic signed [COORD_BITS-1:0] v;
	logic signed [COORD_BITS-1:0] vu [pqt_pkg::NUM_EDGES];
	logic signed [COORD_BITS-1:0] vv [pqt_pkg::NUM_EDGES];

	assign u = (plane == pqt_pkg::PLANE_YZ) ? py : px;
	assign v = (plane == pqt_pkg::PLANE_XY) ? py : pz;

	for (genvar i = 0; i < pqt_pkg::NUM_EDGES; i++) begin : g_edge
		localparam int J = (i + pqt_pkg::NUM_EDGES - 1) % pqt_pkg::NUM_EDGES;

		logic straddle;
		logic near;
		logic in_span;
		logic cross_en;

		assign vu[i] = signed'(vtx[i][2*COORD_BITS-1:COORD_BITS]);
		assign vv[i] = signed'(vtx[i][COORD_BITS-1:0]);

		assign straddle = (vv[i] < v && vv[J] >= v) || (vv[J] < v && vv[i] >= v);
		assign near     = (vu[i] <= u) || (vu[J] <= u);
		assign in_span  = (vu[i] <= u && vu[J] >= u) || (vu[J] <= u && vu[i] >= u);
		assign cross_en = straddle && near;

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s1[i] <= DW'(v) - DW'(vv[i]);
				dx_s1[i] <= DW'(vu[J]) - DW'(vu[i]);
				du_s1[i] <= DW'(u) - DW'(vu[i]);
				dy_s1[i] <= DW'(vv[J]) - DW'(vv[i]);
				flags_s1[i].cross_en <= cross_en;
				flags_s1[i].on_end   <= !cross_en && in_span && (vv[i] == v || vv[J] == v);
				flags_s1[i].den_pos  <= vv[J] > vv[i];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pqt_edge_mul.sv -----
//------------------------------------------------------------------------------
// Point-in-quad cross product stage
// Forms both cross-multiplied products of every edge.
//------------------------------------------------------------------------------
`default_nettype none

module pqt_edge_mul #(
	parameter int COORD_BITS = 24,
	localparam int DW = COORD_BITS + 1,
	localparam int PW = 2 * DW
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [DW-1:0] dv_s1 [pqt_pkg::NUM_EDGES],
	input  wire logic signed [DW-1:0] dx_s1 [pqt_pkg::NUM_EDGES],
	input  wire logic signed [DW-1:0] du_s1 [pqt_pkg::NUM_EDGES],
	input  wire logic signed [DW-1:0] dy_s1 [pqt_pkg::NUM_EDGES],
	input  wire pqt_pkg::pqt_quad_flags_t flags_s1,
	output logic signed [PW-1:0]      lhs_s2 [pqt_pkg::NUM_EDGES],
	output logic signed [PW-1:0]      rhs_s2 [pqt_pkg::NUM_EDGES],
	output pqt_pkg::pqt_quad_flags_t  flags_s2
);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < pqt_pkg::NUM_EDGES; i++) begin
				lhs_s2[i] <= PW'(dv_s1[i]) * PW'(dx_s1[i]);
				rhs_s2[i] <= PW'(du_s1[i]) * PW'(dy_s1[i]);
			end
			flags_s2 <= flags_s1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pqt_decide.sv -----
//------------------------------------------------------------------------------
// Point-in-quad decision stage
// Compares the products and folds the edge outcomes into one result.
//------------------------------------------------------------------------------
`default_nettype none

module pqt_decide #(
	parameter int COORD_BITS = 24,
	localparam int PW = 2 * (COORD_BITS + 1)
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic signed [PW-1:0] lhs_s2 [pqt_pkg::NUM_EDGES],
	input  wire logic signed [PW-1:0] rhs_s2 [pqt_pkg::NUM_EDGES],
	input  wire pqt_pkg::pqt_quad_flags_t flags_s2,
	output logic                     inside_s3
);

	logic [pqt_pkg::NUM_EDGES-1:0] hit;
	logic [pqt_pkg::NUM_EDGES-1:0] toggle;

	always_comb begin
		for (int i = 0; i < pqt_pkg::NUM_EDGES; i++) begin
			hit[i]    = (flags_s2[i].cross_en && lhs_s2[i] == rhs_s2[i]) ||
				flags_s2[i].on_end;
			toggle[i] = flags_s2[i].cross_en && lhs_s2[i] != rhs_s2[i] &&
				(flags_s2[i].den_pos ? (lhs_s2[i] < rhs_s2[i]) : (lhs_s2[i] > rhs_s2[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s3 <= (|hit) || (^toggle);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pqt_checker.sv -----
//------------------------------------------------------------------------------
// Point-in-quad port checker
// Watches the point and result channels of the top level over time.
//------------------------------------------------------------------------------
`default_nettype none

module pqt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_inside
);

	logic       in_acc;
	logic       out_acc;
	logic [2:0] cnt_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_inside))
		else $error("result beat dropped or changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> cnt_q != 3'd0)
		else $error("result beat without an outstanding point");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd3)
		else $error("more points in flight than pipeline stages");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && cnt_q == 3'd0 |-> ##3 out_valid)
		else $error("result beat late on an empty pipeline");

endmodule

bind point_in_quad_test_top pqt_checker u_pqt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (point.valid),
	.in_ready   (point.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_inside (result.inside_res)
);

`default_nettype wire

// ----- dv/tb_point_in_quad_test_top.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Point-in-quad test bench
// Streams 3D points through the block under random gaps on both channels and
// checks every inside verdict against a bit-exact ray casting predictor that
// follows each configured plane and quad.
//------------------------------------------------------------------------------
module tb_point_in_quad_test_top;

	localparam int COORD_BITS       = 24;
	localparam int VTX_BITS         = 2 * COORD_BITS;
	localparam int STALL_LIMIT      = 1000;
	localparam int MAX_REPORTS      = 10;
	localparam int DRAIN_CYCLES     = 8;
	localparam int RESET_CYCLES     = 8;
	localparam int RANDOM_PHASES    = 12;
	localparam int POINTS_PER_PHASE = 50;
	localparam int MAX_GAP          = 9;

	localparam logic [pqt_pkg::CFG_IDX_BITS-1:0] REG_FIRST_UNUSED =
		pqt_pkg::REG_VERTEX_D + 1'b1;
	localparam logic [pqt_pkg::PLANE_BITS-1:0]   PLANE_UNUSED     = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	localparam coord_t UNIT      = coord_t'(1 << 12);
	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	class inside_verdicts;
		logic [pqt_pkg::PLANE_BITS-1:0] plane;
		logic [VTX_BITS-1:0]            corner[pqt_pkg::NUM_EDGES];
		bit                             expected_inside[$];
		int                             errors;

		function new();
			plane = pqt_pkg::PLANE_XY;
			foreach (corner[i])
				corner[i] = '0;
			errors = 0;
		endfunction

		function void set_register(logic [pqt_pkg::CFG_IDX_BITS-1:0] index,
			logic [VTX_BITS-1:0] data);
			if (index == pqt_pkg::REG_PLANE)
				plane = data[pqt_pkg::PLANE_BITS-1:0];
			else if (index >= pqt_pkg::REG_VERTEX_A && index <= pqt_pkg::REG_VERTEX_D)
				corner[index - pqt_pkg::REG_VERTEX_A] = data;
		endfunction

		function bit ray_cast(point_t p);
			coord_t  pu, pv;
			coord_t  cu[pqt_pkg::NUM_EDGES];
			coord_t  cv[pqt_pkg::NUM_EDGES];
			longint  u, v, xi, yi, xj, yj, den, lhs, rhs;
			bit      odd, hit, straddle;
			int      j;
			odd = 1'b0;
			hit = 1'b0;
			pu = (plane == pqt_pkg::PLANE_YZ) ? p.y : p.x;
			pv = (plane == pqt_pkg::PLANE_XY) ? p.y : p.z;
			u = longint'(pu);
			v = longint'(pv);
			for (int k = 0; k < pqt_pkg::NUM_EDGES; k++) begin
				cu[k] = corner[k][VTX_BITS-1:COORD_BITS];
				cv[k] = corner[k][COORD_BITS-1:0];
			end
			for (int i = 0; i < pqt_pkg::NUM_EDGES && !hit; i++) begin
				j = (i + pqt_pkg::NUM_EDGES - 1) % pqt_pkg::NUM_EDGES;
				xi = longint'(cu[i]);
				yi = longint'(cv[i]);
				xj = longint'(cu[j]);
				yj = longint'(cv[j]);
				straddle = (yi < v && yj >= v) || (yj < v && yi >= v);
				if (straddle && (xi <= u || xj <= u)) begin
					den = yj - yi;
					lhs = (v - yi) * (xj - xi);
					rhs = (u - xi) * den;
					if (lhs == rhs)
						hit = 1'b1;
					else if ((den > 0) ? (lhs < rhs) : (lhs > rhs))
						odd = !odd;
				end else if (((xi <= u && xj >= u) || (xj <= u && xi >= u)) &&
					(yi == v || yj == v)) begin
					hit = 1'b1;
				end
			end
			return hit || odd;
		endfunction

		function void note_point(point_t p);
			expected_inside = {expected_inside, ray_cast(p)};
		endfunction

		function void check_verdict(logic actual);
			bit want;
			if (expected_inside.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("result beat with no point pending: inside_res=%0b", actual);
				return;
			end
			want = expected_inside.pop_front();
			if (actual !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("inside_res mismatch: expected %0b, actual %0b", want, actual);
			end
		endfunction

		function int pending();
			return expected_inside.size();
		endfunction
	endclass

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             cfg_we    = 1'b0;
	logic [pqt_pkg::CFG_IDX_BITS-1:0] cfg_index = pqt_pkg::REG_PLANE;
	logic [VTX_BITS-1:0]              cfg_data  = '0;

	pqt_point_if #(.COORD_BITS(COORD_BITS)) point_bus();
	pqt_result_if result_bus();

	inside_verdicts verdicts = new();

	bit                             idle_free   = 1'b0;
	int                             stall_count = 0;
	logic [pqt_pkg::PLANE_BITS-1:0] quad_plane  = pqt_pkg::PLANE_XY;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	point_in_quad_test_top #(.COORD_BITS(COORD_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.point     (point_bus),
		.result    (result_bus)
	);

	always @(posedge clk) begin
		if ((point_bus.valid && point_bus.ready) || (result_bus.valid && result_bus.ready) ||
			cfg_we || !arst_n) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("point_in_quad_test_top verification failed");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	function automatic logic [VTX_BITS-1:0] vtx(coord_t u, coord_t v);
		return {u, v};
	endfunction

	function automatic coord_t grid(int step);
		return coord_t'((int'($urandom_range(0, 8)) - 4) * step);
	endfunction

	function automatic point_t place_point(coord_t u, coord_t v);
		point_t p;
		p.x = coord_t'($urandom);
		p.y = coord_t'($urandom);
		p.z = coord_t'($urandom);
		case (quad_plane)
			pqt_pkg::PLANE_XY: begin
				p.x = u;
				p.y = v;
			end
			pqt_pkg::PLANE_YZ: begin
				p.y = u;
				p.z = v;
			end
			default: begin
				p.x = u;
				p.z = v;
			end
		endcase
		return p;
	endfunction

	task automatic write_reg(logic [pqt_pkg::CFG_IDX_BITS-1:0] index,
		logic [VTX_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		verdicts.set_register(index, data);
	endtask

	task automatic load_quad(logic [VTX_BITS-1:0] plane_word, logic [VTX_BITS-1:0] a,
		logic [VTX_BITS-1:0] b, logic [VTX_BITS-1:0] c, logic [VTX_BITS-1:0] d);
		quad_plane = plane_word[pqt_pkg::PLANE_BITS-1:0];
		write_reg(pqt_pkg::REG_PLANE, plane_word);
		write_reg(pqt_pkg::REG_VERTEX_A, a);
		write_reg(pqt_pkg::REG_VERTEX_B, b);
		write_reg(pqt_pkg::REG_VERTEX_C, c);
		write_reg(pqt_pkg::REG_VERTEX_D, d);
		write_reg(pqt_pkg::CFG_IDX_BITS'($urandom_range(REG_FIRST_UNUSED,
			(1 << pqt_pkg::CFG_IDX_BITS) - 1)), VTX_BITS'({$urandom, $urandom}));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_point(point_t p);
		int gap;
		gap = idle_free ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			point_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_bus.valid   <= 1'b1;
		point_bus.point_x <= p.x;
		point_bus.point_y <= p.y;
		point_bus.point_z <= p.z;
		do @(posedge clk); while (!point_bus.ready);
		verdicts.note_point(p);
	endtask

	task automatic drain();
		point_bus.valid <= 1'b0;
		while (verdicts.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : result_sink
		int gap;
		result_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = idle_free ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				result_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (!result_bus.valid);
			verdicts.check_verdict(result_bus.inside_res);
		end
	end

	initial begin : stimulus
		logic [pqt_pkg::PLANE_BITS-1:0] plane;
		logic [VTX_BITS-1:0]            plane_word;
		coord_t                         cu[pqt_pkg::NUM_EDGES];
		coord_t                         cv[pqt_pkg::NUM_EDGES];
		coord_t                         lo_u, hi_u, lo_v, hi_v, u, v;
		longint                         span_u, span_v;
		int                             step, shape, pick, k, j;
		point_bus.valid   = 1'b0;
		point_bus.point_x = '0;
		point_bus.point_y = '0;
		point_bus.point_z = '0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset quad is a single point at the origin.
		send_point(place_point(0, 0));
		send_point(place_point(1, 0));
		send_point(place_point(0, coord_t'(-1)));
		drain();

		load_quad(VTX_BITS'(pqt_pkg::PLANE_XY), vtx(0, 0), vtx(UNIT, 0), vtx(UNIT, UNIT),
			vtx(0, UNIT));
		send_point(place_point(coord_t'(UNIT / 2), coord_t'(UNIT / 2)));
		send_point(place_point(0, 0));
		send_point(place_point(coord_t'(UNIT / 2), 0));
		send_point(place_point(0, coord_t'(UNIT / 2)));
		send_point(place_point(UNIT, coord_t'(UNIT / 2)));
		send_point(place_point(coord_t'(UNIT / 2), UNIT));
		send_point(place_point(coord_t'(-1), coord_t'(UNIT / 2)));
		send_point(place_point(coord_t'(UNIT + 1), coord_t'(UNIT / 2)));
		send_point(place_point(coord_t'(UNIT / 2), coord_t'(UNIT + 1)));
		send_point(place_point(COORD_MAX, COORD_MAX));
		send_point(place_point(COORD_MIN, COORD_MIN));
		drain();

		load_quad(VTX_BITS'(pqt_pkg::PLANE_YZ), vtx(COORD_MIN, COORD_MIN),
			vtx(COORD_MAX, COORD_MIN), vtx(COORD_MAX, COORD_MAX), vtx(COORD_MIN, COORD_MAX));
		send_point(place_point(0, 0));
		send_point(place_point(COORD_MAX, COORD_MAX));
		send_point(place_point(COORD_MIN, 0));
		send_point(place_point(COORD_MAX, COORD_MIN));
		drain();

		// The unused plane code projects like XZ.
		load_quad(VTX_BITS'(PLANE_UNUSED), vtx(0, 0), vtx(coord_t'(3 * UNIT), UNIT),
			vtx(UNIT, coord_t'(3 * UNIT)), vtx(coord_t'(-UNIT), UNIT));
		send_point(place_point(UNIT, UNIT));
		send_point(place_point(coord_t'(2 * UNIT), coord_t'(2 * UNIT)));
		send_point(place_point(coord_t'(-2 * UNIT), UNIT));
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			plane = pqt_pkg::PLANE_BITS'((phase <= PLANE_UNUSED) ? phase :
				$urandom_range(0, PLANE_UNUSED));
			plane_word = VTX_BITS'({$urandom, $urandom});
			plane_word[pqt_pkg::PLANE_BITS-1:0] = plane;
			shape = $urandom_range(0, 9);
			step = $urandom_range(0, 1) ? int'(UNIT) : $urandom_range(1, 1 << 18);
			for (k = 0; k < pqt_pkg::NUM_EDGES; k++) begin
				if (shape >= 6 && shape < 8) begin
					cu[k] = coord_t'($urandom);
					cv[k] = coord_t'($urandom);
				end else begin
					cu[k] = grid(step);
					cv[k] = grid(step);
				end
			end
			if (shape == 8) begin
				cu[1] = cu[0];
				cv[1] = cv[0];
				cu[3] = cu[2];
				cv[3] = cv[2];
			end else if (shape == 9) begin
				for (k = 1; k < pqt_pkg::NUM_EDGES; k++) begin
					cu[k] = cu[0];
					cv[k] = cv[0];
				end
			end
			idle_free = ($urandom_range(0, 3) == 0);
			load_quad(plane_word, vtx(cu[0], cv[0]), vtx(cu[1], cv[1]), vtx(cu[2], cv[2]),
				vtx(cu[3], cv[3]));

			lo_u = cu[0];
			hi_u = cu[0];
			lo_v = cv[0];
			hi_v = cv[0];
			for (k = 1; k < pqt_pkg::NUM_EDGES; k++) begin
				if (cu[k] < lo_u) lo_u = cu[k];
				if (cu[k] > hi_u) hi_u = cu[k];
				if (cv[k] < lo_v) lo_v = cv[k];
				if (cv[k] > hi_v) hi_v = cv[k];
			end
			span_u = longint'(hi_u) - longint'(lo_u);
			span_v = longint'(hi_v) - longint'(lo_v);

			for (int n = 0; n < POINTS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 9);
				k = $urandom_range(0, pqt_pkg::NUM_EDGES - 1);
				j = (k + pqt_pkg::NUM_EDGES - 1) % pqt_pkg::NUM_EDGES;
				u = coord_t'(longint'(lo_u) + longint'($urandom_range(0, span_u)));
				v = coord_t'(longint'(lo_v) + longint'($urandom_range(0, span_v)));
				case (pick)
					0, 1, 2: begin
						u = grid(step);
						v = grid(step);
					end
					3: begin
						u = cu[k];
						v = cv[k];
					end
					4: begin
						u = coord_t'((longint'(cu[k]) + longint'(cu[j])) >>> 1);
						v = coord_t'((longint'(cv[k]) + longint'(cv[j])) >>> 1);
					end
					5: v = cv[k];
					6, 7: ;
					default: begin
						u = coord_t'($urandom);
						v = coord_t'($urandom);
					end
				endcase
				send_point(place_point(u, v));
			end
			drain();
		end

		if (verdicts.errors == 0 && verdicts.pending() == 0)
			$display("point_in_quad_test_top verification clean");
		else
			$display("point_in_quad_test_top verification failed");
		$finish;
	end

endmodule
